### rtl/gti_pkg.sv
// ----------------------------------------------------------------------------
// gti_pkg
// Shared types and codes for the trilinear grid interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package gti_pkg;

  localparam int MAX_I     = 64;
  localparam int MAX_J     = 64;
  localparam int MAX_K     = 16;
  localparam int FRAC_BITS = 16;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_QUERY = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    REG_SIZE_I = 2'd0,
    REG_SIZE_J = 2'd1,
    REG_SIZE_K = 2'd2
  } reg_e;

  typedef struct packed {
    kind_e              kind;
    logic [5:0]         node_i;
    logic [5:0]         node_j;
    logic [3:0]         node_k;
    logic signed [31:0] node_value;
    logic [16:0]        coord_x;
    logic [16:0]        coord_y;
    logic [16:0]        coord_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] interp_value;
    logic               coord_clamped;
  } out_item_t;

  typedef struct packed {
    logic [6:0] size_i;
    logic [6:0] size_j;
    logic [4:0] size_k;
  } cfg_t;

endpackage

`default_nettype wire

### rtl/gti_queue.sv
// ----------------------------------------------------------------------------
// gti_queue
// Small FIFO between the classifying front and the grid back end.
// ----------------------------------------------------------------------------
`default_nettype none

module gti_queue #(
  parameter int DEPTH = 4,
  parameter int W     = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         valid_i,
  output logic              ready_o,
  input  wire logic [W-1:0] data_i,
  output logic              valid_o,
  input  wire logic         ready_i,
  output logic [W-1:0]      data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [W-1:0]    mem_q [DEPTH];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign ready_o = (cnt_q != CNTW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign push    = valid_i && ready_o;
  assign pop     = valid_o && ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

### rtl/gti_front.sv
// ----------------------------------------------------------------------------
// gti_front
// Accepts items, clamps coordinates and resolves cell indices and weights.
// ----------------------------------------------------------------------------
`default_nettype none

module gti_front #(
  parameter int EW        = 115
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire gti_pkg::cfg_t     cfg_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire gti_pkg::in_item_t in_data_i,
  output logic                   q_valid_o,
  input  wire logic              q_ready_i,
  output logic [EW-1:0]          q_data_o
);

  import gti_pkg::*;

  localparam int FB  = FRAC_BITS;
  localparam int IWI = $clog2(MAX_I);
  localparam int IWJ = $clog2(MAX_J);
  localparam int IWK = $clog2(MAX_K);
  localparam int CW  = (FB + 1 > 17) ? FB + 1 : 17;
  localparam int PWI = CW + IWI;
  localparam int PWJ = CW + IWJ;
  localparam int PWK = CW + IWK;
  localparam logic [CW-1:0] ONE = CW'(1) << FB;

  typedef struct packed {
    kind_e              kind;
    logic               clamped;
    logic               wr_ok;
    logic [IWI-1:0]     i_lo;
    logic [IWI-1:0]     i_hi;
    logic [IWJ-1:0]     j_lo;
    logic [IWJ-1:0]     j_hi;
    logic [IWK-1:0]     k_lo;
    logic [IWK-1:0]     k_hi;
    logic [FB-1:0]      fi;
    logic [FB-1:0]      fj;
    logic [FB-1:0]      fk;
    logic signed [31:0] value;
  } entry_t;

  logic           v1_q;
  in_item_t       it1_q;
  logic           clamp1_q, clamp1_d;
  logic [PWI-1:0] pi_q, pi_d;
  logic [PWJ-1:0] pj_q, pj_d;
  logic [PWK-1:0] pk_q, pk_d;
  logic [IWI-1:0] ni_q, ni_d;
  logic [IWJ-1:0] nj_q, nj_d;
  logic [IWK-1:0] nk_q, nk_d;
  logic [CW-1:0]  cx, cy, cz;
  logic [PWI-1:0] loi;
  logic [PWJ-1:0] loj;
  logic [PWK-1:0] lok;
  logic           adv1;
  entry_t         ent;

  assign adv1       = !v1_q || q_ready_i;
  assign in_ready_o = adv1;

  always_comb begin
    cx = CW'(in_data_i.coord_x);
    cy = CW'(in_data_i.coord_y);
    cz = CW'(in_data_i.coord_z);
    clamp1_d = 1'b0;
    if (cx > ONE) begin
      cx = ONE;
      clamp1_d = 1'b1;
    end
    if (cy > ONE) begin
      cy = ONE;
      clamp1_d = 1'b1;
    end
    if (cz > ONE) begin
      cz = ONE;
      clamp1_d = 1'b1;
    end

    if (cfg_i.size_i == '0) begin
      ni_d = '0;
    end else if (32'(cfg_i.size_i) > 32'(MAX_I)) begin
      ni_d = IWI'(MAX_I - 1);
    end else begin
      ni_d = IWI'(cfg_i.size_i - 7'd1);
    end
    if (cfg_i.size_j == '0) begin
      nj_d = '0;
    end else if (32'(cfg_i.size_j) > 32'(MAX_J)) begin
      nj_d = IWJ'(MAX_J - 1);
    end else begin
      nj_d = IWJ'(cfg_i.size_j - 7'd1);
    end
    if (cfg_i.size_k == '0) begin
      nk_d = '0;
    end else if (32'(cfg_i.size_k) > 32'(MAX_K)) begin
      nk_d = IWK'(MAX_K - 1);
    end else begin
      nk_d = IWK'(cfg_i.size_k - 5'd1);
    end

    pi_d = PWI'(cx) * PWI'(ni_d);
    pj_d = PWJ'(cy) * PWJ'(nj_d);
    pk_d = PWK'(cz) * PWK'(nk_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv1) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      it1_q    <= in_data_i;
      clamp1_q <= clamp1_d;
      pi_q     <= pi_d;
      pj_q     <= pj_d;
      pk_q     <= pk_d;
      ni_q     <= ni_d;
      nj_q     <= nj_d;
      nk_q     <= nk_d;
    end
  end

  always_comb begin
    loi = pi_q >> FB;
    loj = pj_q >> FB;
    lok = pk_q >> FB;
    ent = '0;
    ent.kind    = it1_q.kind;
    ent.clamped = clamp1_q;
    ent.value   = it1_q.node_value;
    if (it1_q.kind == KIND_WRITE) begin
      ent.wr_ok = (32'(it1_q.node_i) < 32'(MAX_I)) && (32'(it1_q.node_j) < 32'(MAX_J))
               && (32'(it1_q.node_k) < 32'(MAX_K));
      ent.i_lo = IWI'(it1_q.node_i);
      ent.i_hi = IWI'(it1_q.node_i);
      ent.j_lo = IWJ'(it1_q.node_j);
      ent.j_hi = IWJ'(it1_q.node_j);
      ent.k_lo = IWK'(it1_q.node_k);
      ent.k_hi = IWK'(it1_q.node_k);
    end else begin
      if (loi >= PWI'(ni_q)) begin
        ent.i_lo = ni_q;
        ent.i_hi = ni_q;
      end else begin
        ent.i_lo = IWI'(loi);
        ent.i_hi = IWI'(loi) + 1'b1;
        ent.fi   = pi_q[FB-1:0];
      end
      if (loj >= PWJ'(nj_q)) begin
        ent.j_lo = nj_q;
        ent.j_hi = nj_q;
      end else begin
        ent.j_lo = IWJ'(loj);
        ent.j_hi = IWJ'(loj) + 1'b1;
        ent.fj   = pj_q[FB-1:0];
      end
      if (lok >= PWK'(nk_q)) begin
        ent.k_lo = nk_q;
        ent.k_hi = nk_q;
      end else begin
        ent.k_lo = IWK'(lok);
        ent.k_hi = IWK'(lok) + 1'b1;
        ent.fk   = pk_q[FB-1:0];
      end
    end
  end

  assign q_valid_o = v1_q;
  assign q_data_o  = ent;

`ifndef SYNTH
  a_i_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> (ent.i_hi == ent.i_lo) || (ent.i_hi == ent.i_lo + 1'b1))
    else $error("i neighbor out of span");
  a_j_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> (ent.j_hi == ent.j_lo) || (ent.j_hi == ent.j_lo + 1'b1))
    else $error("j neighbor out of span");
  a_k_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && (ent.fk != '0) |-> (ent.k_hi == ent.k_lo + 1'b1))
    else $error("k weight on a single node");
`endif

endmodule

`default_nettype wire

### rtl/gti_back.sv
// ----------------------------------------------------------------------------
// gti_back
// Banked grid store and the three rounded interpolation stages.
// ----------------------------------------------------------------------------
`default_nettype none

module gti_back #(
  parameter int EW        = 115
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_valid_i,
  output logic                q_ready_o,
  input  wire logic [EW-1:0]  q_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output gti_pkg::out_item_t  out_data_o
);

  import gti_pkg::*;

  localparam int FB  = FRAC_BITS;
  localparam int IWI = $clog2(MAX_I);
  localparam int IWJ = $clog2(MAX_J);
  localparam int IWK = $clog2(MAX_K);
  localparam int HI  = (MAX_I + 1) / 2;
  localparam int HJ  = (MAX_J + 1) / 2;
  localparam int HK  = (MAX_K + 1) / 2;
  localparam int BD  = HI * HJ * HK;
  localparam int AW  = (BD > 1) ? $clog2(BD) : 1;
  localparam int PRW = 34 + FB;

  typedef struct packed {
    kind_e              kind;
    logic               clamped;
    logic               wr_ok;
    logic [IWI-1:0]     i_lo;
    logic [IWI-1:0]     i_hi;
    logic [IWJ-1:0]     j_lo;
    logic [IWJ-1:0]     j_hi;
    logic [IWK-1:0]     k_lo;
    logic [IWK-1:0]     k_hi;
    logic [FB-1:0]      fi;
    logic [FB-1:0]      fj;
    logic [FB-1:0]      fk;
    logic signed [31:0] value;
  } entry_t;

  typedef struct packed {
    logic          clamped;
    logic          ip_lo;
    logic          ip_hi;
    logic          jp_lo;
    logic          jp_hi;
    logic          kp_lo;
    logic          kp_hi;
    logic [FB-1:0] fi;
    logic [FB-1:0] fj;
    logic [FB-1:0] fk;
  } meta_t;

  function automatic logic signed [31:0] lerp(input logic signed [31:0] a,
                                              input logic signed [31:0] b,
                                              input logic [FB-1:0] f);
    logic signed [32:0]    d;
    logic signed [PRW-1:0] s;
    logic signed [PRW-1:0] sh;
    d  = {b[31], b} - {a[31], a};
    s  = d * $signed({1'b0, f});
    s  = s + (PRW'(1) <<< (FB - 1));
    sh = s >>> FB;
    return a + sh[31:0];
  endfunction

  function automatic logic [AW-1:0] bank_addr(input logic [IWI-1:0] i,
                                              input logic [IWJ-1:0] j,
                                              input logic [IWK-1:0] k);
    logic [AW-1:0] a;
    a = (AW'(k >> 1) * AW'(HJ) + AW'(j >> 1)) * AW'(HI) + AW'(i >> 1);
    return a;
  endfunction

  entry_t             e;
  logic               adv0, adv1, adv2, advo;
  logic               v0_q, v1_q, v2_q, vo_q;
  logic               take;
  meta_t              m0_q;
  logic [AW-1:0]      addr [8];
  logic               we [8];
  logic signed [31:0] bank_d [8];
  logic signed [31:0] r1_q [2][2];
  logic signed [31:0] r2_q [2];
  logic [FB-1:0]      fj1_q, fk1_q, fk2_q;
  logic               cl1_q, cl2_q;
  out_item_t          out_q;

  assign e    = q_data_i;
  assign advo = !vo_q || out_ready_i;
  assign adv2 = !v2_q || advo;
  assign adv1 = !v1_q || adv2;
  assign adv0 = !v0_q || adv1;
  assign take = adv0 && q_valid_i;
  assign q_ready_o = adv0;

  always_comb begin
    logic [IWI-1:0] ii;
    logic [IWJ-1:0] jj;
    logic [IWK-1:0] kk;
    for (int b = 0; b < 8; b++) begin
      ii = (e.i_lo[0] == b[0]) ? e.i_lo : e.i_hi;
      jj = (e.j_lo[0] == b[1]) ? e.j_lo : e.j_hi;
      kk = (e.k_lo[0] == b[2]) ? e.k_lo : e.k_hi;
      addr[b] = bank_addr(ii, jj, kk);
      we[b]   = (e.kind == KIND_WRITE) && e.wr_ok
             && ({e.k_lo[0], e.j_lo[0], e.i_lo[0]} == b[2:0]);
    end
  end

  for (genvar g = 0; g < 8; g++) begin : g_bank
    logic [31:0] mem [BD];
    logic [31:0] rd_q;
    always_ff @(posedge clk_i) begin
      if (take) begin
        if (we[g]) begin
          mem[addr[g]] <= e.value;
        end
        rd_q <= mem[addr[g]];
      end
    end
    assign bank_d[g] = $signed(rd_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (adv0) begin
        v0_q <= q_valid_i && (e.kind == KIND_QUERY);
      end
      if (adv1) begin
        v1_q <= v0_q;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
      if (advo) begin
        vo_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      m0_q.clamped <= e.clamped;
      m0_q.ip_lo   <= e.i_lo[0];
      m0_q.ip_hi   <= e.i_hi[0];
      m0_q.jp_lo   <= e.j_lo[0];
      m0_q.jp_hi   <= e.j_hi[0];
      m0_q.kp_lo   <= e.k_lo[0];
      m0_q.kp_hi   <= e.k_hi[0];
      m0_q.fi      <= e.fi;
      m0_q.fj      <= e.fj;
      m0_q.fk      <= e.fk;
    end
    if (adv1 && v0_q) begin
      for (int dj = 0; dj < 2; dj++) begin
        for (int dk = 0; dk < 2; dk++) begin
          r1_q[dj][dk] <= lerp(
            bank_d[{(dk != 0) ? m0_q.kp_hi : m0_q.kp_lo,
                    (dj != 0) ? m0_q.jp_hi : m0_q.jp_lo, m0_q.ip_lo}],
            bank_d[{(dk != 0) ? m0_q.kp_hi : m0_q.kp_lo,
                    (dj != 0) ? m0_q.jp_hi : m0_q.jp_lo, m0_q.ip_hi}],
            m0_q.fi);
        end
      end
      fj1_q <= m0_q.fj;
      fk1_q <= m0_q.fk;
      cl1_q <= m0_q.clamped;
    end
    if (adv2 && v1_q) begin
      r2_q[0] <= lerp(r1_q[0][0], r1_q[1][0], fj1_q);
      r2_q[1] <= lerp(r1_q[0][1], r1_q[1][1], fj1_q);
      fk2_q   <= fk1_q;
      cl2_q   <= cl1_q;
    end
    if (advo && v2_q) begin
      out_q.interp_value  <= lerp(r2_q[0], r2_q[1], fk2_q);
      out_q.coord_clamped <= cl2_q;
    end
  end

  assign out_valid_o = vo_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### rtl/grid_trilinear_interp.sv
// ----------------------------------------------------------------------------
// grid_trilinear_interp
// Stored 3-D grid with node writes and trilinear interpolation queries.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+----------------------------
//  in      | in_valid_i/in_ready_o  | in_data_i  (in_item_t)
//  out     | out_valid_o/out_ready_i| out_data_o (out_item_t)
//  cfg     | psel/penable/pready    | paddr, pwdata, prdata
//
//  One item per cycle while the output is not stalled.
//  Eight parity banks of the grid give all eight corners in a single read.
//  Reset clears the size registers to 1 and empties the pipeline and queue;
//  grid contents are undefined until written, with no clearing pass.
//  Output stalls back up the interpolation stages into a four-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_trilinear_interp (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire gti_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output gti_pkg::out_item_t      out_data_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  import gti_pkg::*;

  localparam int IWI = $clog2(MAX_I);
  localparam int IWJ = $clog2(MAX_J);
  localparam int IWK = $clog2(MAX_K);
  localparam int EW  = 35 + 2 * (IWI + IWJ + IWK) + 3 * FRAC_BITS;

  cfg_t          cfg_q;
  logic          wr_en;
  logic          q_in_valid, q_in_ready, q_out_valid, q_out_ready;
  logic [EW-1:0] q_in_data, q_out_data;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.size_i <= 7'd1;
      cfg_q.size_j <= 7'd1;
      cfg_q.size_k <= 5'd1;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_SIZE_I: cfg_q.size_i <= pwdata[6:0];
        REG_SIZE_J: cfg_q.size_j <= pwdata[6:0];
        REG_SIZE_K: cfg_q.size_k <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SIZE_I: prdata = {25'd0, cfg_q.size_i};
      REG_SIZE_J: prdata = {25'd0, cfg_q.size_j};
      REG_SIZE_K: prdata = {27'd0, cfg_q.size_k};
      default:    prdata = '0;
    endcase
  end

  gti_front #(
    .EW(EW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_in_valid),
    .q_ready_i  (q_in_ready),
    .q_data_o   (q_in_data)
  );

  gti_queue #(
    .DEPTH(4), .W(EW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_in_valid),
    .ready_o (q_in_ready),
    .data_i  (q_in_data),
    .valid_o (q_out_valid),
    .ready_i (q_out_ready),
    .data_o  (q_out_data)
  );

  gti_back #(
    .EW(EW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_out_valid),
    .q_ready_o   (q_out_ready),
    .q_data_i    (q_out_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

### dv/tb_grid_trilinear_interp.sv
// ----------------------------------------------------------------------------
// tb_grid_trilinear_interp
// Self-checking bench for the trilinear grid interpolator. Several size
// settings follow one another; each fills the nodes in use with random
// values, then runs directed corner queries and random write/query traffic
// under random sender bursts and receiver stalls. Results are predicted in
// the bench and compared in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_grid_trilinear_interp;
  import gti_pkg::*;

  localparam int        ONE       = 65536;
  localparam int        SETTLE    = 20;
  localparam longint    MAX_CYCLE = 2000000;

  class interp_scoreboard;
    bit [31:0]  grid [65536];
    int         n_i = 1, n_j = 1, n_k = 1;
    out_item_t  expected [$];
    int         errors = 0;

    function void report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endfunction

    function void set_size(reg_e idx, int value);
      case (idx)
        REG_SIZE_I: n_i = value;
        REG_SIZE_J: n_j = value;
        default:    n_k = value;
      endcase
    endfunction

    function int clip(int s, int mx);
      if (s == 0) return 1;
      return (s > mx) ? mx : s;
    endfunction

    function longint blend(longint a, longint b, longint f);
      longint s;
      s = a * (ONE - f) + b * f + ONE / 2;
      return s >>> 16;
    endfunction

    function void split(int c, int n, output int lo, output int hi, output int f);
      longint p;
      p = longint'(c) * (n - 1);
      lo = int'(p >> 16);
      f = int'(p & (ONE - 1));
      if (lo + 1 >= n) begin
        lo = n - 1;
        hi = n - 1;
        f = 0;
      end else begin
        hi = lo + 1;
      end
    endfunction

    function longint node(int i, int j, int k);
      return longint'($signed(grid[(k * 64 + j) * 64 + i]));
    endfunction

    function longint plane(int k, int i0, int i1, int fi, int j0, int j1, int fj);
      return blend(blend(node(i0, j0, k), node(i1, j0, k), fi),
                   blend(node(i0, j1, k), node(i1, j1, k), fi), fj);
    endfunction

    function void note_input(in_item_t it);
      int c [3];
      int i0, i1, fi, j0, j1, fj, k0, k1, fk;
      out_item_t r;
      if (it.kind == KIND_WRITE) begin
        grid[(int'(it.node_k) * 64 + int'(it.node_j)) * 64 + int'(it.node_i)] = it.node_value;
        return;
      end
      c[0] = it.coord_x;
      c[1] = it.coord_y;
      c[2] = it.coord_z;
      r.coord_clamped = 1'b0;
      for (int a = 0; a < 3; a++) begin
        if (c[a] > ONE) begin
          c[a] = ONE;
          r.coord_clamped = 1'b1;
        end
      end
      split(c[0], clip(n_i, 64), i0, i1, fi);
      split(c[1], clip(n_j, 64), j0, j1, fj);
      split(c[2], clip(n_k, 16), k0, k1, fk);
      r.interp_value = 32'(blend(plane(k0, i0, i1, fi, j0, j1, fj),
                                 plane(k1, i0, i1, fi, j0, j1, fj), fk));
      expected.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_item;
      if (expected.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      exp_item = expected.pop_front();
      if (got.interp_value !== exp_item.interp_value)
        report($sformatf("interp_value got %h want %h", got.interp_value,
                         exp_item.interp_value));
      if (got.coord_clamped !== exp_item.coord_clamped)
        report($sformatf("coord_clamped got %b want %b", got.coord_clamped,
                         exp_item.coord_clamped));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_item_t   out_data_o;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  interp_scoreboard sb = new();
  longint cycles = 0;
  int     burst_left = 0;
  bit     hold_req = 1'b0;
  int     stall_mode = 0;

  grid_trilinear_interp DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLE) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  // receiver: stall pattern plus a single long hold-off
  initial begin
    int hold_cnt;
    int span;
    bit held;
    hold_cnt = 0;
    span = 0;
    held = 1'b0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !held && hold_cnt == 0) begin
        hold_cnt = 400;
        held = 1'b1;
      end
      if (span == 0) begin
        stall_mode = $urandom_range(0, 3);
        span = $urandom_range(16, 128);
      end
      span--;
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready_i <= 1'b0;
      end else begin
        case (stall_mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= ($urandom_range(0, 7) != 0);
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send_item(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(it);
  endtask

  task automatic go_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, int value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 4'(4 * int'(idx));
    pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_size(idx, value);
    @(posedge clk_i);
  endtask

  task automatic set_sizes(int si, int sj, int sk);
    go_idle();
    write_reg(REG_SIZE_I, si);
    write_reg(REG_SIZE_J, sj);
    write_reg(REG_SIZE_K, sk);
  endtask

  function automatic in_item_t noise_item();
    in_item_t    it;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    it = raw[99:0];
    return it;
  endfunction

  function automatic in_item_t write_item(int i, int j, int k, logic [31:0] v);
    in_item_t it;
    it = noise_item();
    it.kind = KIND_WRITE;
    it.node_i = 6'(i);
    it.node_j = 6'(j);
    it.node_k = 4'(k);
    it.node_value = v;
    return it;
  endfunction

  function automatic in_item_t query_item(int x, int y, int z);
    in_item_t it;
    it = noise_item();
    it.kind = KIND_QUERY;
    it.coord_x = 17'(x);
    it.coord_y = 17'(y);
    it.coord_z = 17'(z);
    return it;
  endfunction

  function automatic int rand_coord();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 131071);
      1:       return ONE;
      2:       return 0;
      default: return $urandom_range(0, ONE - 1);
    endcase
  endfunction

  function automatic int rand_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return $urandom_range(0, 1) ? 32'h7fff_0000 : 32'h8001_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic fill_region();
    int ni, nj, nk;
    ni = sb.clip(sb.n_i, 64);
    nj = sb.clip(sb.n_j, 64);
    nk = sb.clip(sb.n_k, 16);
    for (int k = 0; k < nk; k++)
      for (int j = 0; j < nj; j++)
        for (int i = 0; i < ni; i++)
          send_item(write_item(i, j, k, rand_value()));
  endtask

  task automatic corner_queries();
    send_item(query_item(0, 0, 0));
    send_item(query_item(ONE, ONE, ONE));
    send_item(query_item(131071, 131071, 131071));
    send_item(query_item(ONE + 1, 0, 0));
    send_item(query_item(0, ONE + 1, 0));
    send_item(query_item(0, 0, ONE + 1));
    send_item(query_item(ONE - 1, ONE - 1, ONE - 1));
    send_item(query_item(ONE / 2, ONE / 2, ONE / 2));
    send_item(query_item(1, 1, 1));
    send_item(query_item(65535, 1, 32768));
    send_item(query_item(131071, 0, ONE));
  endtask

  task automatic random_traffic(int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 3) == 0)
        send_item(write_item($urandom_range(0, 63), $urandom_range(0, 63),
                             $urandom_range(0, 15), rand_value()));
      else
        send_item(query_item(rand_coord(), rand_coord(), rand_coord()));
    end
  endtask

  initial begin
    int si [8];
    int sj [8];
    int sk [8];
    si = '{1, 64, 2, 0, 127, 5, 3, 7};
    sj = '{1, 1, 3, 64, 1, 1, 2, 5};
    sk = '{1, 2, 2, 0, 1, 16, 31, 3};
    rst_ni = 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int p = 0; p < 8; p++) begin
      set_sizes(si[p], sj[p], sk[p]);
      fill_region();
      corner_queries();
      if (p == 2) hold_req = 1'b1;
      random_traffic(60);
    end

    go_idle();
    if (sb.expected.size() != 0)
      sb.report("results still outstanding at end");
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
